[hw/rtl/bffa_pkg.sv]
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared sizes, codes and controller/datapath interface types of the
// first-fit block allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

   localparam int BLOCKS   = 1024;
   localparam int FIELD_W  = 11;
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int BLK_W    = $clog2(BLOCKS + 1);
   // wide enough for a block number plus a count without overflow
   localparam int NUM_W    = ((BLK_W > FIELD_W) ? BLK_W : FIELD_W) + 1;

   typedef logic [NUM_W-1:0] num_type;

   localparam num_type BLOCKS_NUM = num_type'(BLOCKS);
   localparam num_type NUM_ONE    = num_type'(1);

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_BOUNDS  = 2'd2
   } status_type;

   typedef enum logic {
      ACT_ALLOC   = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_MARK,
      S_FREE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       take;
      logic       load_req;
      logic       scan_start;
      logic       scan_step;
      logic       wr_en;
      logic       wr_data;
      logic       wr_load_mark;
      logic       wr_load_free;
      logic       res_set;
      status_type res_status;
      logic       res_with_start;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_release;
      logic bad_alloc;
      logic bad_release;
      logic zero_count;
      logic run_hit;
      logic scan_end;
      logic wr_last;
      logic rsp_free;
   } sts_type;

endpackage

[hw/rtl/bffa_ram.sv]
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bffa_ctrl.sv]
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer of the allocator: clear pass, request decode, map scan,
// run marking, range release and result hand-off.
// ----------------------------------------------------------------------------
module bffa_ctrl
   import bffa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in           = state_ff;
      cmd                = '0;
      cmd.res_status     = ST_DONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_data = 1'b0;
            if (sts.wr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.take = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.is_release) begin
               if (sts.bad_alloc) begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ST_NOSPACE;
                  state_in       = S_FINISH;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end else if (sts.bad_release) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_BOUNDS;
               state_in       = S_FINISH;
            end else if (sts.zero_count) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_DONE;
               state_in       = S_FINISH;
            end else begin
               cmd.wr_load_free = 1'b1;
               state_in         = S_FREE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.run_hit) begin
               cmd.wr_load_mark   = 1'b1;
               cmd.res_set        = 1'b1;
               cmd.res_status     = ST_DONE;
               cmd.res_with_start = 1'b1;
               state_in           = S_MARK;
            end else if (sts.scan_end) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_NOSPACE;
               state_in       = S_FINISH;
            end
         end
         S_MARK: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_data = 1'b1;
            if (sts.wr_last) begin
               state_in = S_FINISH;
            end
         end
         S_FREE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_data = 1'b0;
            if (sts.wr_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_DONE;
               state_in       = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the output register can take the result
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/bffa_dp.sv]
// ----------------------------------------------------------------------------
// bffa_dp
// Datapath of the allocator: request registers, used-block map, scan
// pipeline with run counter, write pointer and output register.
// ----------------------------------------------------------------------------
module bffa_dp
   import bffa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                req_action,
   input  logic [FIELD_W-1:0]  req_first_block,
   input  logic [FIELD_W-1:0]  req_block_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FIELD_W-1:0]  rsp_run_start
);

   // control registers
   logic       chk_vld_ff,  chk_vld_in;
   logic       rsp_valid_ff, rsp_valid_in;
   num_type    wr_blk_ff,   wr_blk_in;
   num_type    wr_end_ff,   wr_end_in;

   // payload registers
   action_type         act_ff,       act_in;
   num_type            first_ff,     first_in;
   num_type            count_ff,     count_in;
   num_type            rd_blk_ff,    rd_blk_in;
   num_type            chk_blk_ff,   chk_blk_in;
   num_type            run_ff,       run_in;
   num_type            begin_ff,     begin_in;
   status_type         res_status_ff, res_status_in;
   logic [FIELD_W-1:0] res_start_ff, res_start_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0] rsp_start_ff, rsp_start_in;

   logic    map_used;
   num_type first_sum;
   num_type begin_eff;
   num_type run_inc;
   logic    hit;

   bffa_ram #(
      .WIDTH (1),
      .DEPTH (BLOCKS)
   ) u_map (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (ADDR_W'(wr_blk_ff - NUM_ONE)),
      .wr_data (cmd.wr_data),
      .rd_en   (cmd.scan_step),
      .rd_addr (ADDR_W'(rd_blk_ff - NUM_ONE)),
      .rd_data (map_used)
   );

   assign first_sum = first_ff + count_ff;
   assign begin_eff = (run_ff == '0) ? chk_blk_ff : begin_ff;
   assign run_inc   = run_ff + NUM_ONE;
   assign hit       = chk_vld_ff & ~map_used & (run_inc == count_ff);

   always_comb begin
      sts             = '0;
      sts.is_release  = (act_ff == ACT_RELEASE);
      sts.bad_alloc   = (count_ff == '0) || (count_ff > BLOCKS_NUM);
      sts.bad_release = (first_ff == '0) || (first_ff > BLOCKS_NUM) ||
                        (first_sum > (BLOCKS_NUM + NUM_ONE));
      sts.zero_count  = (count_ff == '0);
      sts.run_hit     = hit;
      sts.scan_end    = chk_vld_ff & (chk_blk_ff == BLOCKS_NUM) & ~hit;
      sts.wr_last     = (wr_blk_ff == wr_end_ff);
      sts.rsp_free    = ~rsp_valid_ff | ~rsp_stall;
   end

   always_comb begin
      act_in        = act_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      rd_blk_in     = rd_blk_ff;
      chk_blk_in    = chk_blk_ff;
      chk_vld_in    = chk_vld_ff;
      run_in        = run_ff;
      begin_in      = begin_ff;
      wr_blk_in     = wr_blk_ff;
      wr_end_in     = wr_end_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;

      if (cmd.load_req) begin
         act_in   = action_type'(req_action);
         first_in = num_type'(req_first_block);
         count_in = num_type'(req_block_count);
      end

      if (cmd.scan_start) begin
         rd_blk_in  = NUM_ONE;
         run_in     = '0;
         chk_vld_in = 1'b0;
      end else begin
         chk_vld_in = cmd.scan_step & (rd_blk_ff <= BLOCKS_NUM);
         if (cmd.scan_step) begin
            rd_blk_in  = rd_blk_ff + NUM_ONE;
            chk_blk_in = rd_blk_ff;
            if (chk_vld_ff) begin
               // a used block restarts the run
               if (map_used) begin
                  run_in = '0;
               end else begin
                  run_in   = run_inc;
                  begin_in = begin_eff;
               end
            end
         end
      end

      if (cmd.wr_load_mark) begin
         wr_blk_in = begin_eff;
         wr_end_in = begin_eff + count_ff - NUM_ONE;
      end else if (cmd.wr_load_free) begin
         wr_blk_in = first_ff;
         wr_end_in = first_sum - NUM_ONE;
      end else if (cmd.wr_en) begin
         wr_blk_in = wr_blk_ff + NUM_ONE;
      end

      if (cmd.res_set) begin
         res_status_in = cmd.res_status;
         res_start_in  = cmd.res_with_start ? FIELD_W'(begin_eff) : '0;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_start_in  = res_start_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         // point the write pointer at the whole map for the clear pass
         wr_blk_ff    <= NUM_ONE;
         wr_end_ff    <= BLOCKS_NUM;
      end else begin
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_blk_ff    <= wr_blk_in;
         wr_end_ff    <= wr_end_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      first_ff      <= first_in;
      count_ff      <= count_in;
      rd_blk_ff     <= rd_blk_in;
      chk_blk_ff    <= chk_blk_in;
      run_ff        <= run_in;
      begin_ff      <= begin_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_run_start = rsp_start_ff;

endmodule

[hw/rtl/bitmap_first_fit_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_unit
// First-fit allocator of contiguous block runs over a one-bit used map.
// A req_ transfer carries an allocate (count) or a release (first, count);
// each gives exactly one rsp_ transfer with a status and the run start.
// After reset the map is cleared one block per cycle, with req_stall held
// high until the clear pass ends. The block works on one request at a
// time. An allocate scans the map bit-serially through its read port up to
// the last block of the first fitting run, or to the map end if none fits,
// then marks the found run with one map write per block. A release clears
// the run with one map write per block; a rejected request writes no block.
// The result sits in an output register, so the next request is taken while
// it waits. A stalled receiver holds the result; a finished later request
// then waits until the output register frees.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator_unit
   import bffa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [FIELD_W-1:0]  req_first_block,
   input  logic [FIELD_W-1:0]  req_block_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FIELD_W-1:0]  rsp_run_start
);

   cmd_type cmd;
   sts_type sts;

   bffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   bffa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_first_block (req_first_block),
      .req_block_count (req_block_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_run_start   (rsp_run_start)
   );

   assign req_stall = ~cmd.take;

   // a transfer in makes the block busy on the next cycle
   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a previous one is in flight");

   // failed requests never report a run start
   a_fail_no_start : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |-> rsp_run_start == '0)
      else $error("failed request carries a run start");

   // the clear pass blocks requests right after reset
   a_clear_stalls : assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("request path open during map clear");

   // a successful allocate reports a block inside the map
   a_start_in_range : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && (rsp_status == ST_DONE) && (rsp_run_start != '0)
      |-> num_type'(rsp_run_start) <= BLOCKS_NUM)
      else $error("run start beyond the map");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit contiguous block allocator. It sends
// allocate and release requests over the req_ channel and keeps its own copy
// of the used map to predict each rsp_ transfer. It checks every result
// field by field, in order. Both channels idle at random, and the receiver
// holds off long enough to fill the block.
// ----------------------------------------------------------------------------
module tb_top
   import bffa_pkg::*;
;

   typedef struct {
      status_type              status;
      logic [FIELD_W-1:0]      run_start;
   } grant_type;

   typedef struct {
      int first;
      int count;
   } run_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_action;
   logic [FIELD_W-1:0]  req_first_block;
   logic [FIELD_W-1:0]  req_block_count;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [FIELD_W-1:0]  rsp_run_start;

   bit        block_used [1:BLOCKS];
   grant_type awaited_grants[$];
   run_type   held_runs[$];
   int        mismatch_count = 0;
   int        hold_cycles = 0;
   bit        send_gaps = 1'b1;
   bit        stall_noise = 1'b1;

   bitmap_first_fit_block_allocator_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_first_block (req_first_block),
      .req_block_count (req_block_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_run_start   (rsp_run_start)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Apply one request to the local used map and return what the block owes.
   function automatic void predict_grant(input action_type act, input int first,
                                         input int count, output status_type status,
                                         output int start);
      int run_len;
      int run_base;
      status = ST_NOSPACE;
      start = 0;
      run_len = 0;
      run_base = 0;
      if (act == ACT_ALLOC) begin
         if (count > 0 && count <= BLOCKS) begin
            for (int b = 1; b <= BLOCKS && start == 0; b++) begin
               if (block_used[b]) begin
                  run_len = 0;
               end else begin
                  if (run_len == 0) run_base = b;
                  run_len++;
                  if (run_len == count) start = run_base;
               end
            end
            if (start != 0) begin
               for (int k = start; k < start + count; k++) block_used[k] = 1'b1;
               status = ST_DONE;
            end
         end
      end else if (first == 0 || first > BLOCKS || first + count > BLOCKS + 1) begin
         status = ST_BOUNDS;
      end else begin
         for (int k = first; k < first + count; k++) block_used[k] = 1'b0;
         status = ST_DONE;
      end
   endfunction

   task automatic send_request(input action_type act, input int first, input int count,
                               output status_type status, output int start);
      grant_type grant;
      int        gap;
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_action      <= act;
      req_first_block <= FIELD_W'(first);
      req_block_count <= FIELD_W'(count);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_grant(act, first, count, status, start);
      grant.status    = status;
      grant.run_start = FIELD_W'(start);
      awaited_grants.push_back(grant);
   endtask

   // Mostly allocate and give back whole runs; the rest is stray releases.
   task automatic send_random_request();
      run_type    run;
      status_type status;
      int         start;
      int         pick;
      int         idx;
      int         count;
      pick = $urandom_range(0, 99);
      if (held_runs.size() != 0 && (pick < 40 || held_runs.size() > 40)) begin
         idx = $urandom_range(0, held_runs.size() - 1);
         run = held_runs[idx];
         held_runs.delete(idx);
         send_request(ACT_RELEASE, run.first, run.count, status, start);
      end else if (pick < 52) begin
         count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, BLOCKS)
                                            : $urandom_range(0, 32);
         send_request(ACT_RELEASE, $urandom_range(0, BLOCKS), count, status, start);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 3)       count = 0;
         else if (pick < 73) count = $urandom_range(1, 16);
         else if (pick < 93) count = $urandom_range(17, 128);
         else                count = $urandom_range(129, BLOCKS);
         send_request(ACT_ALLOC, $urandom_range(0, BLOCKS), count, status, start);
         if (status == ST_DONE) begin
            run.first = start;
            run.count = count;
            held_runs.push_back(run);
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_grants.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_corners();
      status_type status;
      int         start;
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), 0,      status, start);
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), BLOCKS, status, start);
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), 1,      status, start);
      send_request(ACT_RELEASE, 0,          1,      status, start);
      send_request(ACT_RELEASE, BLOCKS + 1, 0,      status, start);
      send_request(ACT_RELEASE, BLOCKS,     2,      status, start);
      send_request(ACT_RELEASE, 1,          0,      status, start);
      send_request(ACT_RELEASE, 1,          BLOCKS, status, start);
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), 4, status, start);
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), 4, status, start);
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), 4, status, start);
      // open a two-block hole with used blocks right after it
      send_request(ACT_RELEASE, 5, 2, status, start);
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), 3, status, start);
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), 2, status, start);
      send_request(ACT_RELEASE, 100, 10, status, start);
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), BLOCKS - 15, status, start);
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), 1, status, start);
      send_request(ACT_RELEASE, BLOCKS, 1, status, start);
      send_request(ACT_RELEASE, BLOCKS, 0, status, start);
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), 1, status, start);
      send_request(ACT_ALLOC,   $urandom_range(0, BLOCKS), 2, status, start);
      send_request(ACT_RELEASE, 1, BLOCKS, status, start);
   endtask

   task automatic test_random_mix(input int items);
      repeat (items) send_random_request();
   endtask

   task automatic test_result_backpressure();
      send_gaps = 1'b0;
      hold_cycles = 600;
      repeat (12) send_random_request();
      send_gaps = 1'b1;
   endtask

   task automatic test_drain_pause();
      repeat (5) send_random_request();
      wait_drained();
      repeat (5) send_random_request();
   endtask

   task automatic test_quiet_tail();
      send_gaps = 1'b0;
      stall_noise = 1'b0;
      repeat (60) send_random_request();
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (stall_noise && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_grant
      grant_type grant;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_grants.size() == 0) begin
            $display("%0t: unexpected transfer, status %0d run_start %0d",
                     $time, rsp_status, rsp_run_start);
            mismatch_count++;
         end else begin
            grant = awaited_grants.pop_front();
            if (rsp_status !== grant.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, grant.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_run_start !== grant.run_start) begin
               $display("%0t: run_start expected %0d actual %0d",
                        $time, grant.run_start, rsp_run_start);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_ALLOC;
      req_first_block = '0;
      req_block_count = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_mix(400);
      test_result_backpressure();
      test_drain_pause();
      test_quiet_tail();
      wait_drained();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/bffa_pkg.sv
hw/rtl/bffa_ram.sv
hw/rtl/bffa_ctrl.sv
hw/rtl/bffa_dp.sv
hw/rtl/bitmap_first_fit_block_allocator_unit.sv
bench/tb_top.sv
